// ===== hw/rtl/rsq_pkg.sv =====
// Package for the range successor query block.
// Field widths, parameter defaults and request codes.
// No dependencies.
package rsq_pkg;

    // fixed widths of the beat fields
    localparam int unsigned IDX_W  = 10;
    localparam int unsigned LEN_W  = 11;
    localparam int unsigned WVAL_W = 32;

    // parameter defaults
    localparam int unsigned DEF_DEPTH      = 1024;
    localparam int unsigned DEF_VALUE_BITS = 32;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

endpackage

// ===== hw/rtl/rsq_in_if.sv =====
// Request channel interface: valid/ready plus the request payload.
// Depends on rsq_pkg.
interface rsq_in_if import rsq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [IDX_W-1:0]  write_index;
    logic [WVAL_W-1:0] write_value;
    logic [IDX_W-1:0]  range_lo;
    logic [IDX_W-1:0]  range_hi;

    modport source (
        output valid, req_type, write_index, write_value, range_lo, range_hi,
        input  ready
    );
    modport sink (
        input  valid, req_type, write_index, write_value, range_lo, range_hi,
        output ready
    );
endinterface

// ===== hw/rtl/rsq_out_if.sv =====
// Result channel interface: valid/ready plus the query result payload.
// Depends on rsq_pkg.
interface rsq_out_if import rsq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] position;
    logic             bad_range;

    modport source (
        output valid, found, position, bad_range,
        input  ready
    );
    modport sink (
        input  valid, found, position, bad_range,
        output ready
    );
endinterface

// ===== hw/rtl/range_successor_query.sv =====
// Channel   Dir  Beat contents                                   Result
// i_req     in   req_type, write_index, write_value, lo, hi      -
// o_rsp     out  found, position, bad_range                      one per query
// i_cfg_*   in   used_length (11 bits), write enable + data      -
//
// A write beat is stored in the RAM at the accept edge.
// A query reads its target entry (index hi + 1), then scans lo..hi one entry
// per cycle from the value RAM; a query with a bad range goes straight to the
// result stage without a scan. The single RAM read port sets the scan rate.
// Reset (i_rst_n, synchronous, active low) clears control state and
// used_length; RAM contents stay undefined until written.
// A stalled result holds in the output register; new requests are still taken until a later query waits in ST_FIN.
// Depends on rsq_pkg, rsq_in_if, rsq_out_if and rsq_ram.
module range_successor_query import rsq_pkg::*; #(
    parameter int unsigned DEPTH      = DEF_DEPTH,
    parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rsq_in_if.sink           i_req,
    rsq_out_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata
);

    localparam int unsigned AW = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TGT  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [LEN_W-1:0]      r_used_len;
    logic [AW-1:0]         r_lo, n_lo;
    logic [AW-1:0]         r_hi, n_hi;
    logic [AW-1:0]         r_pos, n_pos;
    logic [VALUE_BITS-1:0] r_target, n_target;
    logic [VALUE_BITS-1:0] r_best, n_best;
    logic [AW-1:0]         r_best_pos, n_best_pos;
    logic                  r_found, n_found;
    logic                  r_bad, n_bad;

    logic                  r_out_valid;
    logic                  r_out_found;
    logic [IDX_W-1:0]      r_out_pos;
    logic                  r_out_bad;

    logic                  req_acc;
    logic                  out_free;
    logic [31:0]           eff_len;
    logic [31:0]           hi_plus1;
    logic                  range_bad;
    logic                  ram_we;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic                  hit;

    // handshake
    assign i_req.ready = (r_state == ST_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    // range check: length clamped to depth
    assign eff_len   = (32'(r_used_len) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(r_used_len);
    assign hi_plus1  = 32'(i_req.range_hi) + 32'd1;
    assign range_bad = (i_req.range_lo > i_req.range_hi) || (hi_plus1 >= eff_len);

    // writes beyond the depth are dropped
    assign ram_we = req_acc && (i_req.req_type == REQ_WRITE)
                    && (32'(i_req.write_index) < 32'(DEPTH));

    // qualifying value: at least the target, and no larger than the best so far
    assign hit = (ram_rdata >= r_target) && (!r_found || (ram_rdata <= r_best));

    // read port: target at accept, then lo..hi
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_pos + AW'(1);
        case (r_state)
            ST_IDLE: begin
                ram_re    = req_acc && (i_req.req_type == REQ_QUERY);
                ram_raddr = AW'(hi_plus1);
            end
            ST_TGT: begin
                ram_re    = 1'b1;
                ram_raddr = r_lo;
            end
            ST_SCAN: begin
                ram_re    = (r_pos != r_hi);
                ram_raddr = r_pos + AW'(1);
            end
            default: begin
                ram_re    = 1'b0;
                ram_raddr = r_pos + AW'(1);
            end
        endcase
    end

    rsq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_req.write_index)),
        .i_wdata (VALUE_BITS'(i_req.write_value)),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // query sequencer
    always_comb begin
        n_state    = r_state;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_pos      = r_pos;
        n_target   = r_target;
        n_best     = r_best;
        n_best_pos = r_best_pos;
        n_found    = r_found;
        n_bad      = r_bad;
        case (r_state)
            ST_IDLE: begin
                if (req_acc && (i_req.req_type == REQ_QUERY)) begin
                    n_lo    = AW'(i_req.range_lo);
                    n_hi    = AW'(i_req.range_hi);
                    n_found = 1'b0;
                    n_bad   = range_bad;
                    n_state = range_bad ? ST_FIN : ST_TGT;
                end
            end
            ST_TGT: begin
                n_target = ram_rdata;
                n_pos    = r_lo;
                n_state  = ST_SCAN;
            end
            ST_SCAN: begin
                if (hit) begin
                    n_found    = 1'b1;
                    n_best     = ram_rdata;
                    n_best_pos = r_pos;
                end
                if (r_pos == r_hi) begin
                    n_state = ST_FIN;
                end else begin
                    n_pos = r_pos + AW'(1);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_used_len <= '0;
            r_found    <= 1'b0;
            r_bad      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
            r_bad   <= n_bad;
            if (i_cfg_we) begin
                r_used_len <= i_cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_pos      <= n_pos;
        r_target   <= n_target;
        r_best     <= n_best;
        r_best_pos <= n_best_pos;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && out_free) begin
            r_out_found <= r_found && !r_bad;
            r_out_pos   <= (r_found && !r_bad) ? IDX_W'(r_best_pos) : '0;
            r_out_bad   <= r_bad;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.found     = r_out_found;
    assign o_rsp.position  = r_out_pos;
    assign o_rsp.bad_range = r_out_bad;

    // checks
    a_bad_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.bad_range && o_rsp.found))
        else $error("result beat with both bad_range and found");

    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.position == '0))
        else $error("result beat without hit carries a position");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((r_pos >= r_lo) && (r_pos <= r_hi)))
        else $error("scan pointer left the query range");

    a_good_query_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && (i_req.req_type == REQ_QUERY) && !range_bad)
        |=> ##1 (r_state == ST_SCAN))
        else $error("valid query did not start its scan");

endmodule

// ===== hw/rtl/rsq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port,
// read data registered. No dependencies.
module rsq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
